FILE: src/assert_macros.svh
// Assertion macros used by the port checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: src/kst_pkg.sv
// Shared types and constants for the keypad interval timer.
// No dependencies.
package kst_pkg;

    // Input mode codes
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_KEY  = 1'b1;

    // Key codes
    localparam logic [3:0] KEY_DIGIT_LO = 4'd0;
    localparam logic [3:0] KEY_DIGIT_HI = 4'd9;
    localparam logic [3:0] KEY_START    = 4'd10;
    localparam logic [3:0] KEY_TOGGLE   = 4'd11;
    localparam logic [3:0] KEY_LEDS_OFF = 4'd12;
    localparam logic [3:0] KEY_CLEAR    = 4'd14;

    // Interval limits and register reset
    localparam logic [7:0] SET_LIMIT = 8'd60;
    localparam logic [5:0] SET_MAX   = 6'd59;
    localparam logic [7:0] DIGIT_WEIGHT = 8'd10;
    localparam logic [6:0] TPS_RESET = 7'd10;

    typedef struct packed {
        logic [6:0] sub_ticks;
        logic [5:0] elapsed;
        logic [5:0] set_value;
        logic [3:0] tens_digit;
        logic [3:0] ones_digit;
        logic       run_flag;
        logic       led_flag;
    } kst_state_t;

    typedef struct packed {
        logic [5:0] set_seconds;
        logic [5:0] elapsed_seconds;
        logic       running;
        logic       leds_on;
        logic       alarm;
    } kst_result_t;

endpackage

FILE: src/kst_step.sv
// Next-state and result logic for one tick or key event.
// Depends on kst_pkg.
module kst_step (
    input  kst_pkg::kst_state_t  state,
    input  logic                 mode,
    input  logic [3:0]           key,
    input  logic [6:0]           ticks_per_second,
    output kst_pkg::kst_state_t  state_next,
    output kst_pkg::kst_result_t result
);
    import kst_pkg::*;

    logic [6:0] sub_inc;
    logic [7:0] entry;
    logic       alarm_hit;

    assign sub_inc = state.sub_ticks + 7'd1;
    assign entry   = {4'd0, state.ones_digit} * DIGIT_WEIGHT + {4'd0, key};

    // Decode the event and advance the timer state
    always_comb
    begin
        state_next = state;
        alarm_hit  = 1'b0;
        if (mode == MODE_KEY)
        begin
            unique case (key) inside
                [KEY_DIGIT_LO:KEY_DIGIT_HI]:
                begin
                    // shift the entry only while stopped
                    if (!state.run_flag)
                    begin
                        state_next.tens_digit = state.ones_digit;
                        state_next.ones_digit = key;
                        state_next.set_value  = (entry < SET_LIMIT) ? entry[5:0] : SET_MAX;
                    end
                end
                KEY_START:
                begin
                    state_next.led_flag  = 1'b0;
                    state_next.run_flag  = 1'b1;
                    state_next.elapsed   = '0;
                    state_next.sub_ticks = '0;
                end
                KEY_TOGGLE:
                begin
                    state_next.run_flag  = !state.run_flag;
                    state_next.sub_ticks = '0;
                end
                KEY_LEDS_OFF:
                begin
                    state_next.led_flag = 1'b0;
                end
                KEY_CLEAR:
                begin
                    state_next.run_flag   = 1'b0;
                    state_next.elapsed    = '0;
                    state_next.set_value  = '0;
                    state_next.sub_ticks  = '0;
                    state_next.tens_digit = '0;
                    state_next.ones_digit = '0;
                end
                default:
                begin
                    // unused keys leave the state alone
                    state_next = state;
                end
            endcase
        end
        else if (state.run_flag)
        begin
            // prescale ticks to seconds
            if (sub_inc < ticks_per_second)
            begin
                state_next.sub_ticks = sub_inc;
            end
            else
            begin
                state_next.sub_ticks = '0;
                if (state.elapsed < state.set_value)
                begin
                    state_next.elapsed = state.elapsed + 6'd1;
                end
                else
                begin
                    // interval expired: restart and light the LEDs
                    state_next.elapsed  = '0;
                    state_next.led_flag = 1'b1;
                    alarm_hit           = 1'b1;
                end
            end
        end
    end

    // Build the result from the updated state
    always_comb
    begin
        result.set_seconds     = state_next.set_value;
        result.elapsed_seconds = state_next.elapsed;
        result.running         = state_next.run_flag;
        result.leds_on         = state_next.led_flag;
        result.alarm           = alarm_hit;
    end

endmodule

FILE: src/kst_out_buf.sv
// Two-entry output buffer: result register plus skid register.
// Depends on kst_pkg.
module kst_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  kst_pkg::kst_result_t push_data,
    output logic                 can_push,
    output logic                 out_valid,
    input  logic                 out_ready,
    output kst_pkg::kst_result_t out_data
);
    import kst_pkg::*;

    logic        head_valid_reg;
    kst_result_t head_data_reg;
    logic        skid_valid_reg;
    kst_result_t skid_data_reg;

    assign can_push  = !skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_data_reg;

    // Control: occupancy of the two entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (head_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                head_valid_reg <= 1'b1;
            end
        end
        else if (out_ready)
        begin
            head_valid_reg <= 1'b0;
        end
    end

    // Payload: move skid forward or load the new result
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                head_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (head_valid_reg && !out_ready)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                head_data_reg <= push_data;
            end
        end
    end

endmodule

FILE: src/keypad_set_interval_alarm_timer.sv
// Keypad-set seconds interval timer. Each input transfer is one timer tick
// or one key event and yields exactly one result, which is registered in the
// output buffer. The timer state updates in one pass of small logic, so a new
// item is taken every cycle; results sit in a two-entry output buffer and
// in_ready drops only while both entries hold results not yet taken.
// Depends on kst_pkg, kst_step and kst_out_buf.
module keypad_set_interval_alarm_timer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    input  logic [3:0] key,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [5:0] set_seconds,
    output logic [5:0] elapsed_seconds,
    output logic       running,
    output logic       leds_on,
    output logic       alarm
);
    import kst_pkg::*;

    logic [6:0]  tps_val_reg;
    kst_state_t  state_reg;
    kst_state_t  state_next;
    kst_result_t step_result;
    kst_result_t out_data;
    logic        in_xfer;

    assign in_xfer = in_valid && in_ready;

    // Hold the ticks-per-second register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_val_reg <= TPS_RESET;
        end
        else if (cfg_we)
        begin
            tps_val_reg <= cfg_wdata;
        end
    end

    // Advance the timer state on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_xfer)
        begin
            state_reg <= state_next;
        end
    end

    kst_step u_step (
        .state            (state_reg),
        .mode             (mode),
        .key              (key),
        .ticks_per_second (tps_val_reg),
        .state_next       (state_next),
        .result           (step_result)
    );

    kst_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_xfer),
        .push_data (step_result),
        .can_push  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign set_seconds     = out_data.set_seconds;
    assign elapsed_seconds = out_data.elapsed_seconds;
    assign running         = out_data.running;
    assign leds_on         = out_data.leds_on;
    assign alarm           = out_data.alarm;

endmodule

FILE: src/kst_checker.sv
// Port-level checks for the keypad interval timer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module kst_port_assertions (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [5:0] set_seconds,
    input logic [5:0] elapsed_seconds,
    input logic       running,
    input logic       leds_on,
    input logic       alarm
);

    // A waiting result stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // An expiring interval restarts at zero and lights the LEDs while running
    `ASSERT_IMPLY(a_alarm_restart, clk, rst_n, out_valid && alarm,
                  elapsed_seconds == 6'd0 && leds_on && running)

    // Set interval and elapsed count stay within a minute
    `ASSERT_IMPLY(a_range, clk, rst_n, out_valid,
                  set_seconds <= 6'd59 && elapsed_seconds <= 6'd59)

    // Input is refused only when a result is waiting
    `ASSERT_IMPLY(a_ready_backpressure, clk, rst_n, !in_ready, out_valid)

endmodule

bind keypad_set_interval_alarm_timer kst_port_assertions u_kst_port_assertions (.*);

FILE: tb/sv/kst_checker.sv
`timescale 1ns / 100ps
// Checker for the keypad interval timer: watches config, input and result transfers,
// predicts every timer reading and compares it with what the block returns.
// Depends on kst_pkg.
module kst_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       mode,
    input  logic [3:0] key,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [5:0] set_seconds,
    input  logic [5:0] elapsed_seconds,
    input  logic       running,
    input  logic       leds_on,
    input  logic       alarm,
    output int         fail_count,
    output int         pending
);
    import kst_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Private copy of the timer state and the prescaler setting
    kst_state_t  timer_st;
    logic [6:0]  tick_div;
    kst_result_t readings_q[$];

    // Apply one event to the timer copy and return the reading it produces
    function automatic kst_result_t predict_reading(input logic m, input logic [3:0] k);
        kst_result_t r;
        logic [7:0]  entry;
        r.alarm = 1'b0;
        if (m == MODE_KEY) begin
            if (k <= KEY_DIGIT_HI) begin
                // digits only shift in while stopped
                if (!timer_st.run_flag) begin
                    timer_st.tens_digit = timer_st.ones_digit;
                    timer_st.ones_digit = k;
                    entry = timer_st.tens_digit * DIGIT_WEIGHT + timer_st.ones_digit;
                    timer_st.set_value = (entry < SET_LIMIT) ? entry[5:0] : SET_MAX;
                end
            end
            else if (k == KEY_LEDS_OFF) begin
                timer_st.led_flag = 1'b0;
            end
            else if (k == KEY_START) begin
                timer_st.led_flag  = 1'b0;
                timer_st.run_flag  = 1'b1;
                timer_st.elapsed   = '0;
                timer_st.sub_ticks = '0;
            end
            else if (k == KEY_TOGGLE) begin
                timer_st.run_flag  = ~timer_st.run_flag;
                timer_st.sub_ticks = '0;
            end
            else if (k == KEY_CLEAR) begin
                timer_st.run_flag   = 1'b0;
                timer_st.elapsed    = '0;
                timer_st.set_value  = '0;
                timer_st.sub_ticks  = '0;
                timer_st.tens_digit = '0;
                timer_st.ones_digit = '0;
            end
        end
        else if (timer_st.run_flag) begin
            // prescale ticks, then count seconds toward the set value
            timer_st.sub_ticks = timer_st.sub_ticks + 7'd1;
            if (timer_st.sub_ticks >= tick_div) begin
                timer_st.sub_ticks = '0;
                if (timer_st.elapsed < timer_st.set_value) begin
                    timer_st.elapsed = timer_st.elapsed + 6'd1;
                end
                else begin
                    timer_st.elapsed  = '0;
                    timer_st.led_flag = 1'b1;
                    r.alarm           = 1'b1;
                end
            end
        end
        r.set_seconds     = timer_st.set_value;
        r.elapsed_seconds = timer_st.elapsed;
        r.running         = timer_st.run_flag;
        r.leds_on         = timer_st.led_flag;
        return r;
    endfunction

    task automatic log_failure(input string msg);
        if (fail_count < REPORT_LIMIT)
            $display("[%0t] %s", $realtime, msg);
        fail_count++;
    endtask

    // Compare result transfers first, then queue the reading of a new input transfer
    always @(posedge clk or negedge rst_n)
    begin
        kst_result_t seen;
        kst_result_t want;
        if (!rst_n) begin
            timer_st   = '0;
            tick_div   = TPS_RESET;
            readings_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else begin
            if (out_valid && out_ready) begin
                seen.set_seconds     = set_seconds;
                seen.elapsed_seconds = elapsed_seconds;
                seen.running         = running;
                seen.leds_on         = leds_on;
                seen.alarm           = alarm;
                if (readings_q.size() == 0) begin
                    log_failure($sformatf("unexpected reading set=%0d elapsed=%0d run=%0b leds=%0b alarm=%0b",
                        seen.set_seconds, seen.elapsed_seconds, seen.running, seen.leds_on,
                        seen.alarm));
                end
                else begin
                    want = readings_q.pop_front();
                    if (seen.set_seconds !== want.set_seconds
                        || seen.elapsed_seconds !== want.elapsed_seconds
                        || seen.running !== want.running
                        || seen.leds_on !== want.leds_on
                        || seen.alarm !== want.alarm) begin
                        log_failure($sformatf({"reading mismatch: expected set=%0d elapsed=%0d ",
                            "run=%0b leds=%0b alarm=%0b, got set=%0d elapsed=%0d run=%0b ",
                            "leds=%0b alarm=%0b"},
                            want.set_seconds, want.elapsed_seconds, want.running,
                            want.leds_on, want.alarm, seen.set_seconds, seen.elapsed_seconds,
                            seen.running, seen.leds_on, seen.alarm));
                    end
                end
            end
            if (in_valid && in_ready)
                readings_q.push_back(predict_reading(mode, key));
            if (cfg_we)
                tick_div = cfg_wdata;
            pending = readings_q.size();
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the keypad interval timer testbench: clock, reset, stimulus and verdict.
// Depends on kst_pkg, kst_checker and keypad_set_interval_alarm_timer.
module tb_top;
    import kst_pkg::*;

    localparam int         IDLE_LIMIT   = 2000;
    localparam int         LONG_HOLD    = 60;
    localparam int         PHASE_HALF   = 120;
    localparam logic [3:0] KEY_UNUSED_A = 4'd13;
    localparam logic [3:0] KEY_UNUSED_B = 4'd15;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [6:0] cfg_wdata = TPS_RESET;
    logic       in_valid  = 1'b0;
    logic       mode      = MODE_TICK;
    logic [3:0] key       = KEY_DIGIT_LO;
    logic       out_ready = 1'b0;

    logic       in_ready;
    logic       out_valid;
    logic [5:0] set_seconds;
    logic [5:0] elapsed_seconds;
    logic       running;
    logic       leds_on;
    logic       alarm;

    int         fail_count;
    int         pending;
    int         items_sent    = 0;
    int         idle_cycles   = 0;
    bit         calm          = 1'b0;
    bit         long_hold_req = 1'b0;

    keypad_set_interval_alarm_timer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .key             (key),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .set_seconds     (set_seconds),
        .elapsed_seconds (elapsed_seconds),
        .running         (running),
        .leds_on         (leds_on),
        .alarm           (alarm)
    );

    kst_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .key             (key),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .set_seconds     (set_seconds),
        .elapsed_seconds (elapsed_seconds),
        .running         (running),
        .leds_on         (leds_on),
        .alarm           (alarm),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: random short stalls, one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (long_hold_req)
            begin
                stall_left    = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
                stall_left = int'($urandom_range(1, 4));
            out_ready <= (stall_left == 0);
        end
    end

    // Watchdog: end the run when nothing transfers for too long
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Offer one event; returns at the falling edge after its transfer with valid still high
    task automatic send_item(input logic m, input logic [3:0] k);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        key      <= k;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        @(negedge clk);
    endtask

    // Drop valid and hold until every expected reading has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic write_tick_div(input logic [6:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly program-and-run sequences with random content, some pure noise
    task automatic run_random(input int n_items);
        int target;
        int n;
        int pick;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 1) == 1)
                    send_item(MODE_KEY, KEY_CLEAR);
                // tens digit is mostly zero so intervals stay short
                send_item(MODE_KEY,
                          ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 9)) : 4'd0);
                send_item(MODE_KEY, 4'($urandom_range(0, 9)));
                send_item(MODE_KEY, ($urandom_range(0, 4) == 0) ? KEY_TOGGLE : KEY_START);
                n = int'($urandom_range(5, 150));
                for (int i = 0; i < n && items_sent < target; i++)
                begin
                    pick = int'($urandom_range(0, 39));
                    if (pick == 0)
                        send_item(MODE_KEY, 4'($urandom_range(0, 15)));
                    else if (pick == 1)
                    begin
                        // pause, re-enter the interval, resume
                        send_item(MODE_KEY, KEY_TOGGLE);
                        send_item(MODE_KEY, 4'($urandom_range(0, 9)));
                        send_item(MODE_KEY, 4'($urandom_range(0, 9)));
                        send_item(MODE_KEY, KEY_TOGGLE);
                    end
                    else
                        send_item(MODE_TICK, 4'($urandom_range(0, 15)));
                end
                if ($urandom_range(0, 2) == 0)
                    send_item(MODE_KEY, KEY_LEDS_OFF);
            end
            else
            begin
                n = int'($urandom_range(3, 20));
                for (int i = 0; i < n && items_sent < target; i++)
                    send_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
            end
        end
    endtask

    // Main stimulus
    initial
    begin
        logic [6:0] tick_divs[7];
        tick_divs = '{TPS_RESET, 7'd1, 7'd0, 7'd100, 7'd127, 7'd2, 7'd5};
        tick_divs[6] = 7'($urandom_range(1, 20));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: ignored tick, clamped entry, spare keys, digit while running, alarm
        send_item(MODE_TICK, KEY_DIGIT_LO);
        send_item(MODE_KEY, KEY_DIGIT_HI);
        send_item(MODE_KEY, KEY_DIGIT_HI);
        send_item(MODE_KEY, KEY_DIGIT_LO);
        send_item(MODE_KEY, 4'd3);
        send_item(MODE_KEY, KEY_CLEAR);
        send_item(MODE_KEY, KEY_UNUSED_A);
        send_item(MODE_KEY, KEY_UNUSED_B);
        send_item(MODE_KEY, KEY_LEDS_OFF);
        send_item(MODE_KEY, KEY_START);
        send_item(MODE_KEY, 4'd4);
        for (int i = 0; i < TPS_RESET; i++)
            send_item(MODE_TICK, 4'hF);
        send_item(MODE_KEY, KEY_TOGGLE);
        send_item(MODE_TICK, KEY_DIGIT_LO);
        send_item(MODE_KEY, KEY_TOGGLE);
        send_item(MODE_KEY, KEY_START);

        // Random phases, one per prescaler setting; the last has no idling
        for (int p = 0; p < 7; p++)
        begin
            if (p > 0)
                write_tick_div(tick_divs[p]);
            if (p == 6)
            begin
                calm = 1'b1;
                run_random(2 * PHASE_HALF);
            end
            else
            begin
                long_hold_req = 1'b1;
                run_random(PHASE_HALF);
                drain_results();
                run_random(PHASE_HALF);
            end
        end

        drain_results();
        repeat (3) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
